/* src/tepic_pkg.sv */
// Package: shared types and constants for the TDC edge pairing block.
package tepic_pkg;

    localparam logic [2:0] CMD_HIT   = 3'd0;
    localparam logic [2:0] CMD_INL   = 3'd1;
    localparam logic [2:0] CMD_MAP   = 3'd2;
    localparam logic [2:0] CMD_SHIFT = 3'd3;
    localparam logic [2:0] CMD_EVENT = 3'd4;

    localparam int FRAC_BITS  = 8;
    localparam int CHIP_WIDTH = 8;
    localparam int TIME_W     = 31;

    localparam logic [7:0] ACCEPTED_TYPE_RESET = 8'd208;

    // Classified item passed from the front part to the back part
    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  tdc_index;
        logic [6:0]  chan;
        logic        leading;
        logic [20:0] tdc_value;
        logic [9:0]  table_bin;
        logic [47:0] load_value;
        logic [7:0]  map_plane;
        logic [7:0]  map_strip;
        logic        map_side;
    } item_t;

    // Result item
    typedef struct packed {
        logic        status;
        logic [7:0]  plane;
        logic [7:0]  strip;
        logic        side;
        logic [47:0] leading_time;
        logic [29:0] pulse_width;
    } result_t;

endpackage

/* src/tdc_edge_pairing_inl_correct_top.sv */
// Top level: TDC leading/trailing edge pairing with INL correction.
//
// Takes one item per cycle when the queue has room; an accepted item passes
// through the queue, INL memory read, pairing stage and output register before
// its result appears. After reset the INL memory is cleared one entry per cycle,
// all NUM_TDCS*CHANNELS*BINS entries (294912 by default), with the channel map
// cleared during the same pass, while items wait in the queue; configuration
// writes are taken during that time.
module tdc_edge_pairing_inl_correct_top #(
    parameter int NUM_TDCS = 4,
    parameter int CHANNELS = 72,
    parameter int BINS     = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [1:0]  tdc_index,
    input  logic [3:0]  hptdc_id,
    input  logic [2:0]  channel_in_chip,
    input  logic        leading,
    input  logic [20:0] tdc_value,
    input  logic [7:0]  digit_type,
    input  logic [9:0]  table_bin,
    input  logic [47:0] load_value,
    input  logic [7:0]  map_plane,
    input  logic [7:0]  map_strip,
    input  logic        map_side,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [7:0]  plane,
    output logic [7:0]  strip,
    output logic        side,
    output logic [47:0] leading_time,
    output logic [29:0] pulse_width
);

    logic [7:0]         accepted_type_reg;
    logic               q_valid, q_pop, full, busy;
    tepic_pkg::item_t   q_item;
    tepic_pkg::result_t res;

    // Hold accepted type register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accepted_type_reg <= tepic_pkg::ACCEPTED_TYPE_RESET;
        end
        else if (cfg_we)
        begin
            accepted_type_reg <= cfg_wdata;
        end
    end

    assign in_stall = full;

    tepic_front #(.NUM_TDCS(NUM_TDCS), .CHANNELS(CHANNELS)) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall_n_dummy (!full),
        .accepted_type    (accepted_type_reg),
        .cmd              (cmd),
        .tdc_index        (tdc_index),
        .hptdc_id         (hptdc_id),
        .channel_in_chip  (channel_in_chip),
        .leading          (leading),
        .tdc_value        (tdc_value),
        .digit_type       (digit_type),
        .table_bin        (table_bin),
        .load_value       (load_value),
        .map_plane        (map_plane),
        .map_strip        (map_strip),
        .map_side         (map_side),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .full             (full)
    );

    tepic_back #(.NUM_TDCS(NUM_TDCS), .CHANNELS(CHANNELS), .BINS(BINS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res),
        .busy      (busy)
    );

    assign status       = res.status;
    assign plane        = res.plane;
    assign strip        = res.strip;
    assign side         = res.side;
    assign leading_time = res.leading_time;
    assign pulse_width  = res.pulse_width;

`ifndef SYNTH
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy) else $error("result without work in flight");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_valid) else $error("stall with empty queue");
    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(accepted_type_reg)) else $error("type changed");
`endif

endmodule

/* src/tepic_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module tepic_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/tepic_front.sv */
// Front part: accept items, filter and classify them, and queue them.
module tepic_front #(
    parameter int NUM_TDCS = 4,
    parameter int CHANNELS = 72
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall_n_dummy,
    input  logic [7:0]          accepted_type,
    input  logic [2:0]          cmd,
    input  logic [1:0]          tdc_index,
    input  logic [3:0]          hptdc_id,
    input  logic [2:0]          channel_in_chip,
    input  logic                leading,
    input  logic [20:0]         tdc_value,
    input  logic [7:0]          digit_type,
    input  logic [9:0]          table_bin,
    input  logic [47:0]         load_value,
    input  logic [7:0]          map_plane,
    input  logic [7:0]          map_strip,
    input  logic                map_side,
    output logic                q_valid,
    output tepic_pkg::item_t    q_item,
    input  logic                q_pop,
    output logic                full
);

    localparam int DEPTH = 2;

    tepic_pkg::item_t it;
    logic [6:0]       chan;
    logic             keep;
    logic             push;

    tepic_pkg::item_t q_reg [DEPTH];
    logic [0:0]       wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg;

    // Classify: drop items that can never have an effect
    always_comb
    begin
        chan = 7'(hptdc_id) * 7'(tepic_pkg::CHIP_WIDTH) + 7'(channel_in_chip);
        keep = 1'b0;
        unique case (cmd) inside
            tepic_pkg::CMD_EVENT: keep = 1'b1;
            tepic_pkg::CMD_SHIFT: keep = (32'(tdc_index) < NUM_TDCS);
            tepic_pkg::CMD_INL, tepic_pkg::CMD_MAP:
                keep = (32'(tdc_index) < NUM_TDCS) && (32'(hptdc_id) * 8
                       + 32'(channel_in_chip) < CHANNELS);
            tepic_pkg::CMD_HIT:
                keep = (32'(tdc_index) < NUM_TDCS) && (32'(hptdc_id) * 8
                       + 32'(channel_in_chip) < CHANNELS)
                       && (digit_type == accepted_type);
            default: keep = 1'b0;
        endcase
        it.cmd        = cmd;
        it.tdc_index  = tdc_index;
        it.chan       = chan;
        it.leading    = leading;
        it.tdc_value  = tdc_value;
        it.table_bin  = table_bin;
        it.load_value = load_value;
        it.map_plane  = map_plane;
        it.map_strip  = map_strip;
        it.map_side   = map_side;
    end

    assign full    = (cnt_reg == 2'(DEPTH));
    assign push    = in_valid && in_stall_n_dummy && keep;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_reg[rd_ptr_reg];

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= it;
        end
    end

    // Queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

/* src/tepic_back.sv */
// Back part: table updates, INL correction, edge pairing and result output.
module tepic_back #(
    parameter int NUM_TDCS = 4,
    parameter int CHANNELS = 72,
    parameter int BINS     = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  tepic_pkg::item_t  q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output tepic_pkg::result_t out_res,
    output logic              busy
);

    localparam int SLOTS  = NUM_TDCS * CHANNELS;
    localparam int SW     = $clog2(SLOTS);
    localparam int BW     = $clog2(BINS);
    localparam int IDEPTH = SLOTS * BINS;
    localparam int IW     = $clog2(IDEPTH);
    localparam int TW     = (NUM_TDCS > 1) ? $clog2(NUM_TDCS) : 1;
    localparam int CLR_W  = IW + 1;

    // Stage 1 registers (table read in flight)
    logic             s1_valid_reg;
    tepic_pkg::item_t s1_reg;
    logic [SW-1:0]    s1_slot_reg;
    // Stage 2 registers (corrected time)
    logic             s2_valid_reg;
    tepic_pkg::item_t s2_reg;
    logic [SW-1:0]    s2_slot_reg;
    logic signed [tepic_pkg::TIME_W-1:0] s2_time_reg;

    // Output register
    logic               o_valid_reg;
    tepic_pkg::result_t o_reg;

    // Clearing pass over the INL memory and channel map after reset
    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clearing;

    logic               advance;
    logic [SW-1:0]      slot;
    logic [IW-1:0]      inl_waddr, inl_raddr;
    logic               inl_we;
    logic [15:0]        inl_wdata, inl_rdata;
    logic signed [47:0] lv;

    logic               lead_valid_reg [SLOTS];
    logic [47:0]        shift_reg [NUM_TDCS];
    logic               shift_valid_reg [NUM_TDCS];

    // Leading time and channel map memories, read while the item sits in stage 1
    logic                         lead_we;
    logic [tepic_pkg::TIME_W-1:0] lead_rdata;
    logic                         map_item_we;
    logic                         map_we;
    logic [SW-1:0]                map_waddr;
    logic [16:0]                  map_wdata, map_item_data, map_rdata;
    logic                         lead_fwd_reg, map_fwd_reg;
    logic [tepic_pkg::TIME_W-1:0] lead_fwd_data_reg;
    logic [16:0]                  map_fwd_data_reg;
    logic [tepic_pkg::TIME_W-1:0] lead_cur;
    logic [16:0]                  map_cur;

    logic               s2_emit;
    tepic_pkg::result_t res;
    logic signed [tepic_pkg::TIME_W-1:0] lead_t;
    logic signed [48:0] lt_sum;
    logic signed [tepic_pkg::TIME_W:0]   diff;
    logic signed [tepic_pkg::TIME_W-1:0] t_now;

    assign clearing = !clr_cnt_reg[CLR_W-1];
    // Pipeline moves when output can take a result and no clearing pass runs
    assign advance  = !clearing && (!o_valid_reg || !out_stall);
    assign q_pop    = advance && q_valid;
    assign busy     = q_valid || s1_valid_reg || s2_valid_reg || o_valid_reg;
    assign slot     = SW'(32'(q_item.tdc_index) * CHANNELS + 32'(q_item.chan));

    // INL memory access
    always_comb
    begin
        lv = $signed(q_item.load_value);
        if (lv > 48'sd32767)
        begin
            inl_wdata = 16'h7fff;
        end
        else if (lv < -48'sd32768)
        begin
            inl_wdata = 16'h8000;
        end
        else
        begin
            inl_wdata = lv[15:0];
        end
        inl_raddr = IW'(32'(slot) * BINS + 32'(q_item.tdc_value[BW-1:0]));
        inl_waddr = IW'(32'(slot) * BINS + 32'(q_item.table_bin));
        inl_we    = q_pop && (q_item.cmd == tepic_pkg::CMD_INL)
                    && (32'(q_item.table_bin) < BINS);
        if (clearing)
        begin
            inl_waddr = clr_cnt_reg[IW-1:0];
            inl_wdata = '0;
            inl_we    = 1'b1;
        end
    end

    tepic_ram #(.WIDTH(16), .DEPTH(IDEPTH)) u_inl (
        .clk   (clk),
        .we    (inl_we),
        .waddr (inl_waddr),
        .wdata (inl_wdata),
        .re    (advance),
        .raddr (inl_raddr),
        .rdata (inl_rdata)
    );

    // Leading time and channel map writes as items pass stage 2 in order
    always_comb
    begin
        lead_we = advance && s2_valid_reg && (s2_reg.cmd == tepic_pkg::CMD_HIT)
                  && s2_reg.leading && shift_valid_reg[TW'(s2_reg.tdc_index)];
        map_item_we   = advance && s2_valid_reg && (s2_reg.cmd == tepic_pkg::CMD_MAP);
        map_item_data = {s2_reg.map_plane, s2_reg.map_strip, s2_reg.map_side};
        map_we    = map_item_we;
        map_waddr = s2_slot_reg;
        map_wdata = map_item_data;
        if (clearing)
        begin
            map_we    = (32'(clr_cnt_reg) < SLOTS);
            map_waddr = clr_cnt_reg[SW-1:0];
            map_wdata = '0;
        end
    end

    tepic_ram #(.WIDTH(tepic_pkg::TIME_W), .DEPTH(SLOTS)) u_lead (
        .clk   (clk),
        .we    (lead_we),
        .waddr (s2_slot_reg),
        .wdata (s2_time_reg),
        .re    (advance),
        .raddr (s1_slot_reg),
        .rdata (lead_rdata)
    );

    tepic_ram #(.WIDTH(17), .DEPTH(SLOTS)) u_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (advance),
        .raddr (s1_slot_reg),
        .rdata (map_rdata)
    );

    // Forward a write to the slot read at the same edge
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lead_fwd_data_reg <= s2_time_reg;
            map_fwd_data_reg  <= map_item_data;
        end
    end

    assign lead_cur = lead_fwd_reg ? lead_fwd_data_reg : lead_rdata;
    assign map_cur  = map_fwd_reg ? map_fwd_data_reg : map_rdata;

    // Advance clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clearing)
        begin
            clr_cnt_reg <= (32'(clr_cnt_reg) == IDEPTH - 1) ?
                           {1'b1, {IW{1'b0}}} : clr_cnt_reg + 1'b1;
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg      <= q_item;
            s1_slot_reg <= slot;
            s2_reg      <= s1_reg;
            s2_slot_reg <= s1_slot_reg;
            s2_time_reg <= $signed(tepic_pkg::TIME_W'({s1_reg.tdc_value, 8'd0}))
                           + tepic_pkg::TIME_W'($signed(inl_rdata));
        end
    end

    // Pipeline valids and forward flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            lead_fwd_reg <= 1'b0;
            map_fwd_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= q_pop;
            s2_valid_reg <= s1_valid_reg;
            lead_fwd_reg <= lead_we && (s2_slot_reg == s1_slot_reg);
            map_fwd_reg  <= map_item_we && (s2_slot_reg == s1_slot_reg);
        end
    end

    // Shift table, written as items pass stage 2 in order
    always_ff @(posedge clk)
    begin
        if (advance && s2_valid_reg)
        begin
            if (s2_reg.cmd == tepic_pkg::CMD_SHIFT)
            begin
                shift_reg[TW'(s2_reg.tdc_index)] <= s2_reg.load_value;
            end
        end
    end

    // Valid bits of slots and shifts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                lead_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_TDCS; i++)
            begin
                shift_valid_reg[i] <= 1'b0;
            end
        end
        else if (advance && s2_valid_reg)
        begin
            if (s2_reg.cmd == tepic_pkg::CMD_EVENT)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    lead_valid_reg[i] <= 1'b0;
                end
            end
            if (s2_reg.cmd == tepic_pkg::CMD_SHIFT)
            begin
                shift_valid_reg[TW'(s2_reg.tdc_index)] <= 1'b1;
            end
            if (s2_reg.cmd == tepic_pkg::CMD_HIT
                && shift_valid_reg[TW'(s2_reg.tdc_index)])
            begin
                lead_valid_reg[s2_slot_reg] <= s2_reg.leading;
            end
        end
    end

    // Pair trailing edge with stored leading time
    always_comb
    begin
        t_now  = s2_time_reg;
        lead_t = $signed(lead_cur);
        diff   = (tepic_pkg::TIME_W+1)'(t_now) - (tepic_pkg::TIME_W+1)'(lead_t);
        lt_sum = 49'(lead_t) + 49'($signed(shift_reg[TW'(s2_reg.tdc_index)]));
        s2_emit = s2_valid_reg && (s2_reg.cmd == tepic_pkg::CMD_HIT) && !s2_reg.leading
                  && shift_valid_reg[TW'(s2_reg.tdc_index)]
                  && lead_valid_reg[s2_slot_reg];
        res = '0;
        if (diff < 0)
        begin
            res.status = 1'b1;
        end
        else
        begin
            res.plane = map_cur[16:9];
            res.strip = map_cur[8:1];
            res.side  = map_cur[0];
            if (lt_sum > 49'sh7fffffffffff)
            begin
                res.leading_time = 48'h7fffffffffff;
            end
            else if (lt_sum < -49'sh800000000000)
            begin
                res.leading_time = 48'h800000000000;
            end
            else
            begin
                res.leading_time = lt_sum[47:0];
            end
            res.pulse_width = diff[29:0];
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            o_valid_reg <= s2_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            o_reg <= res;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_res   = o_reg;

`ifndef SYNTH
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_res))
        else $error("result changed while stalled");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop) else $error("item taken during clearing");
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_res.status |-> out_res.pulse_width == '0)
        else $error("error result carries width");
`endif

endmodule

/* tb/tb_top.sv */
// Testbench for the TDC edge pairing block with INL correction, scoreboard included.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_TDCS  = 4;
    localparam int CHANNELS  = 72;
    localparam int BINS      = 1024;
    localparam int SLOTS     = NUM_TDCS * CHANNELS;
    localparam int DRAIN_CYC = 12;
    localparam logic [2:0] CMD_UNKNOWN_LO = tepic_pkg::CMD_EVENT + 3'd1;
    localparam longint TIME_MAX = 64'sd140737488355327;
    localparam longint TIME_MIN = -64'sd140737488355328;

    // One hit word as presented on the input ports
    typedef struct {
        logic [2:0]  cmd;
        logic [1:0]  tdc_index;
        logic [3:0]  hptdc_id;
        logic [2:0]  channel_in_chip;
        logic        leading;
        logic [20:0] tdc_value;
        logic [7:0]  digit_type;
        logic [9:0]  table_bin;
        logic [47:0] load_value;
        logic [7:0]  map_plane;
        logic [7:0]  map_strip;
        logic        map_side;
    } hit_word_t;

    // Pairing predictor and store of expected digits
    class digit_scoreboard;
        logic [7:0]  type_sel;
        int          lead_time [SLOTS];
        bit          lead_ok [SLOTS];
        shortint     inl [int];
        logic [16:0] chan_map [SLOTS];
        longint      board_shift [NUM_TDCS];
        bit          shift_ok [NUM_TDCS];
        tepic_pkg::result_t expected_digits [$];
        int          errors;

        function new();
            type_sel = tepic_pkg::ACCEPTED_TYPE_RESET;
            errors = 0;
            foreach (lead_ok[i]) lead_ok[i] = 0;
            foreach (chan_map[i]) chan_map[i] = '0;
            foreach (shift_ok[i]) shift_ok[i] = 0;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        // Advance the predictor by one accepted item
        function void note_item(hit_word_t w);
            int      chan;
            int      s;
            int      key;
            longint  v;
            longint  t;
            longint  lead;
            longint  lt;
            tepic_pkg::result_t r;
            chan = int'(w.hptdc_id) * 8 + int'(w.channel_in_chip);
            s = int'(w.tdc_index) * CHANNELS + chan;
            v = longint'($signed(w.load_value));
            if (w.cmd == tepic_pkg::CMD_EVENT)
            begin
                foreach (lead_ok[i]) lead_ok[i] = 0;
                return;
            end
            if (w.cmd == tepic_pkg::CMD_SHIFT)
            begin
                board_shift[w.tdc_index] = v;
                shift_ok[w.tdc_index] = 1;
                return;
            end
            if (w.cmd > tepic_pkg::CMD_EVENT || chan >= CHANNELS) return;
            if (w.cmd == tepic_pkg::CMD_INL)
            begin
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                inl[s * BINS + int'(w.table_bin)] = shortint'(v);
                return;
            end
            if (w.cmd == tepic_pkg::CMD_MAP)
            begin
                chan_map[s] = {w.map_plane, w.map_strip, w.map_side};
                return;
            end
            // hit
            if (w.digit_type != type_sel || !shift_ok[w.tdc_index]) return;
            key = s * BINS + int'(w.tdc_value % BINS);
            t = (longint'(w.tdc_value) << tepic_pkg::FRAC_BITS)
                + (inl.exists(key) ? inl[key] : 0);
            if (w.leading)
            begin
                lead_time[s] = int'(t);
                lead_ok[s] = 1;
                return;
            end
            if (!lead_ok[s]) return;
            lead_ok[s] = 0;
            lead = lead_time[s];
            r = '0;
            if (t < lead)
            begin
                r.status = 1'b1;
            end
            else
            begin
                lt = lead + board_shift[w.tdc_index];
                if (lt > TIME_MAX) lt = TIME_MAX;
                if (lt < TIME_MIN) lt = TIME_MIN;
                {r.plane, r.strip, r.side} = chan_map[s];
                r.leading_time = lt[47:0];
                r.pulse_width = 30'(t - lead);
            end
            expected_digits.push_back(r);
        endfunction

        // Compare one emitted digit with the oldest expectation
        function void check_digit(tepic_pkg::result_t got);
            tepic_pkg::result_t e;
            if (expected_digits.size() == 0)
            begin
                $error("unexpected digit: status=%0d plane=%0d", got.status, got.plane);
                errors++;
                return;
            end
            e = expected_digits.pop_front();
            if (got.status != e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.plane != e.plane)
            begin
                $error("plane: expected %0d actual %0d", e.plane, got.plane);
                errors++;
            end
            if (got.strip != e.strip)
            begin
                $error("strip: expected %0d actual %0d", e.strip, got.strip);
                errors++;
            end
            if (got.side != e.side)
            begin
                $error("side: expected %0d actual %0d", e.side, got.side);
                errors++;
            end
            if (got.leading_time != e.leading_time)
            begin
                $error("leading_time: expected %h actual %h", e.leading_time,
                    got.leading_time);
                errors++;
            end
            if (got.pulse_width != e.pulse_width)
            begin
                $error("pulse_width: expected %h actual %h", e.pulse_width, got.pulse_width);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  cmd;
    logic [1:0]  tdc_index;
    logic [3:0]  hptdc_id;
    logic [2:0]  channel_in_chip;
    logic        leading;
    logic [20:0] tdc_value;
    logic [7:0]  digit_type;
    logic [9:0]  table_bin;
    logic [47:0] load_value;
    logic [7:0]  map_plane;
    logic [7:0]  map_strip;
    logic        map_side;
    logic        out_valid;
    logic        out_stall;
    logic        status;
    logic [7:0]  plane;
    logic [7:0]  strip;
    logic        side;
    logic [47:0] leading_time;
    logic [29:0] pulse_width;

    digit_scoreboard sb;
    int burst_left;

    tdc_edge_pairing_inl_correct_top #(
        .NUM_TDCS(NUM_TDCS),
        .CHANNELS(CHANNELS),
        .BINS(BINS)
    ) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .tdc_index(tdc_index),
        .hptdc_id(hptdc_id), .channel_in_chip(channel_in_chip), .leading(leading),
        .tdc_value(tdc_value), .digit_type(digit_type), .table_bin(table_bin),
        .load_value(load_value), .map_plane(map_plane), .map_strip(map_strip),
        .map_side(map_side), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .plane(plane), .strip(strip), .side(side),
        .leading_time(leading_time), .pulse_width(pulse_width)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Drive the receiver stall from a pattern whose mode is picked at random from four
    int stall_mode = 0;
    int stall_cnt = 0;
    always @(negedge clk)
    begin
        if (stall_cnt % 64 == 0) stall_mode = $urandom_range(3);
        stall_cnt++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(1) == 0);
            2: out_stall <= ($urandom_range(9) < 8);
            default: out_stall <= (stall_cnt % 3 == 0);
        endcase
    end

    // Check each accepted digit
    always @(posedge clk)
    begin
        tepic_pkg::result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.plane = plane;
            got.strip = strip;
            got.side = side;
            got.leading_time = leading_time;
            got.pulse_width = pulse_width;
            sb.check_digit(got);
        end
    end

    // Fill every field at random
    function automatic hit_word_t random_word();
        hit_word_t w;
        w.cmd = 3'($urandom_range(7));
        w.tdc_index = 2'($urandom);
        w.hptdc_id = 4'($urandom_range(8));
        w.channel_in_chip = 3'($urandom);
        w.leading = 1'($urandom);
        w.tdc_value = 21'($urandom);
        w.digit_type = 8'($urandom);
        w.table_bin = 10'($urandom);
        w.load_value = {16'($urandom), 32'($urandom)};
        w.map_plane = 8'($urandom);
        w.map_strip = 8'($urandom);
        w.map_side = 1'($urandom);
        return w;
    endfunction

    // Drive one item in bursts with random gaps and hold until accepted
    task automatic send_item(hit_word_t w);
        if (burst_left == 0)
        begin
            if ($urandom_range(3) != 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 5)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        cmd <= w.cmd;
        tdc_index <= w.tdc_index;
        hptdc_id <= w.hptdc_id;
        channel_in_chip <= w.channel_in_chip;
        leading <= w.leading;
        tdc_value <= w.tdc_value;
        digit_type <= w.digit_type;
        table_bin <= w.table_bin;
        load_value <= w.load_value;
        map_plane <= w.map_plane;
        map_strip <= w.map_strip;
        map_side <= w.map_side;
        do @(posedge clk); while (in_stall);
        sb.note_item(w);
    endtask

    task automatic send_hit(logic [1:0] tdc, logic [3:0] chip, logic [2:0] ch,
                            logic lead, logic [20:0] val, logic [7:0] dtype);
        hit_word_t w;
        w = random_word();
        w.cmd = tepic_pkg::CMD_HIT;
        w.tdc_index = tdc;
        w.hptdc_id = chip;
        w.channel_in_chip = ch;
        w.leading = lead;
        w.tdc_value = val;
        w.digit_type = dtype;
        send_item(w);
    endtask

    task automatic send_load(logic [2:0] c, logic [1:0] tdc, logic [3:0] chip,
                             logic [2:0] ch, logic [9:0] bin, logic [47:0] v);
        hit_word_t w;
        w = random_word();
        w.cmd = c;
        w.tdc_index = tdc;
        w.hptdc_id = chip;
        w.channel_in_chip = ch;
        w.table_bin = bin;
        w.load_value = v;
        send_item(w);
    endtask

    // Flush with a pairing on the last channel of board 0, then let the block go idle
    task automatic drain();
        send_load(tepic_pkg::CMD_SHIFT, 2'd0, 4'd0, 3'd0, 10'd0, 48'(64'sd1000));
        send_hit(2'd0, 4'd8, 3'd7, 1'b1, 21'($urandom), sb.type_sel);
        send_hit(2'd0, 4'd8, 3'd7, 1'b0, 21'($urandom), sb.type_sel);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic write_type(logic [7:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.type_sel = v;
    endtask

    // One random item or well-formed edge pair
    task automatic random_step();
        hit_word_t   w;
        int          pick;
        logic [1:0]  tdc;
        logic [3:0]  chip;
        logic [2:0]  ch;
        logic [20:0] base;
        pick = $urandom_range(99);
        tdc = 2'($urandom);
        chip = ($urandom_range(2) == 0) ? 4'd8 : 4'($urandom_range(1));
        ch = 3'($urandom);
        base = {11'($urandom), ($urandom_range(1) == 0) ? 10'($urandom_range(15))
                                                         : 10'($urandom)};
        w = random_word();
        if (pick < 45)
        begin
            send_hit(tdc, chip, ch, 1'b1, base, sb.type_sel);
            if ($urandom_range(4) == 0) send_item(random_word());
            send_hit(tdc, chip, ch, 1'b0,
                     ($urandom_range(5) == 0) ? 21'(base - $urandom_range(1, 40))
                                              : 21'(base + $urandom_range(0, 4000)),
                     sb.type_sel);
        end
        else if (pick < 60)
        begin
            send_load(tepic_pkg::CMD_INL, tdc, chip, ch,
                      ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(15)),
                      ($urandom_range(3) == 0) ? w.load_value
                                               : 48'(longint'($urandom_range(60000)) - 30000));
        end
        else if (pick < 65)
        begin
            w.cmd = tepic_pkg::CMD_MAP;
            send_item(w);
        end
        else if (pick < 68)
        begin
            send_load(tepic_pkg::CMD_SHIFT, tdc, 4'd0, 3'd0, 10'd0,
                      ($urandom_range(1) == 0) ? w.load_value : 48'($urandom));
        end
        else if (pick < 70)
        begin
            w.cmd = tepic_pkg::CMD_EVENT;
            send_item(w);
        end
        else if (pick < 80)
        begin
            w.hptdc_id = 4'($urandom);
            if ($urandom_range(1) == 0) w.digit_type = sb.type_sel;
            send_item(w);
        end
        else if (pick < 85)
        begin
            w.cmd = 3'($urandom_range(CMD_UNKNOWN_LO, 7));
            send_item(w);
        end
        else
        begin
            send_hit(tdc, chip, ch, 1'($urandom), base, sb.type_sel);
        end
    endtask

    // Generous limit: clearing pass plus all items under heavy stalls
    initial
    begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        logic [7:0] types [4];
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        {cmd, tdc_index, hptdc_id, channel_in_chip, leading, tdc_value} = '0;
        {digit_type, table_bin, load_value, map_plane, map_strip, map_side} = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_type(tepic_pkg::ACCEPTED_TYPE_RESET);

        // Directed: hit before any shift, loads at the extremes, special cases
        send_hit(2'd1, 4'd0, 3'd0, 1'b1, 21'd100, sb.type_sel);
        send_hit(2'd1, 4'd0, 3'd0, 1'b0, 21'd200, sb.type_sel);
        send_load(tepic_pkg::CMD_SHIFT, 2'd1, 4'd0, 3'd0, 10'd0, 48'd0);
        send_load(tepic_pkg::CMD_SHIFT, 2'd2, 4'd0, 3'd0, 10'd0, 48'h8000_0000_0000);
        send_load(tepic_pkg::CMD_SHIFT, 2'd3, 4'd0, 3'd0, 10'd0, 48'h7FFF_FFFF_FF00);
        send_load(tepic_pkg::CMD_INL, 2'd1, 4'd0, 3'd0, 10'd1023, 48'h7FFF_FFFF_FFFF);
        send_load(tepic_pkg::CMD_INL, 2'd1, 4'd0, 3'd0, 10'd0, 48'h8000_0000_0000);
        send_load(tepic_pkg::CMD_MAP, 2'd1, 4'd0, 3'd0, 10'd0, 48'd0);
        send_load(CMD_UNKNOWN_LO, 2'd1, 4'd0, 3'd0, 10'd0, 48'd0);
        send_load(3'd7, 2'd1, 4'd0, 3'd0, 10'd0, 48'd0);
        send_hit(2'd1, 4'd0, 3'd0, 1'b0, 21'd50, sb.type_sel);
        send_hit(2'd1, 4'd0, 3'd0, 1'b1, 21'd0, sb.type_sel);
        send_hit(2'd1, 4'd0, 3'd0, 1'b1, 21'd1023, sb.type_sel);
        send_hit(2'd1, 4'd0, 3'd0, 1'b0, 21'h1FFFFF, sb.type_sel);
        send_hit(2'd2, 4'd8, 3'd7, 1'b1, 21'd5000, sb.type_sel);
        send_hit(2'd2, 4'd8, 3'd7, 1'b0, 21'd4999, sb.type_sel);
        send_hit(2'd3, 4'd2, 3'd4, 1'b1, 21'h1FFFFF, sb.type_sel);
        send_hit(2'd3, 4'd2, 3'd4, 1'b0, 21'h1FFFFF, sb.type_sel);
        send_hit(2'd3, 4'd15, 3'd7, 1'b1, 21'd7, sb.type_sel);
        send_hit(2'd3, 4'd2, 3'd4, 1'b1, 21'd10, 8'(~sb.type_sel));
        send_hit(2'd3, 4'd2, 3'd5, 1'b1, 21'd10, sb.type_sel);
        send_load(tepic_pkg::CMD_EVENT, 2'd0, 4'd0, 3'd0, 10'd0, 48'd0);
        send_hit(2'd3, 4'd2, 3'd5, 1'b0, 21'd20, sb.type_sel);
        drain();

        // Random phases over several accepted types
        types[0] = 8'd0;
        types[1] = 8'd255;
        types[2] = 8'($urandom);
        types[3] = tepic_pkg::ACCEPTED_TYPE_RESET;
        foreach (types[p])
        begin
            write_type(types[p]);
            repeat (200) random_step();
            drain();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* tdc_edge_pairing_inl_correct_top.f */
src/tepic_pkg.sv
src/tepic_ram.sv
src/tepic_front.sv
src/tepic_back.sv
src/tdc_edge_pairing_inl_correct_top.sv
tb/tb_top.sv
